@@ rtl/gcnt_pkg.sv @@
// Package for the keyed generation counter table.
// Holds the request, response and table entry types, mode codes and helpers.
// No dependencies; gcnt_cmp, gcnt_seq, the top level and the testbench import it.
package gcnt_pkg;

   localparam int KEY_W   = 64;
   localparam int COUNT_W = 31;
   localparam int SEC_W   = 32;
   localparam int MODE_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_MARK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UNMARK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [KEY_W-1:0]   key;
      logic [SEC_W-1:0]   now_sec;
      logic [SEC_W-1:0]   cutoff_sec;
   } gcnt_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               table_full;
   } gcnt_rsp_type;

   // One stored table slot.
   typedef struct packed {
      logic               vld;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
      logic [SEC_W-1:0]   last_sec;
   } gcnt_entry_type;

   // Result of the shared compare unit for one slot.
   typedef struct packed {
      logic key_hit;
      logic stale;
   } gcnt_cmp_type;

   // Increment that holds at the counter maximum.
   function automatic logic [COUNT_W-1:0] gcnt_sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_MAX) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
      return r;
   endfunction

endpackage

@@ rtl/gcnt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the slot storage of the counter table.
module gcnt_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gcnt_cmp.sv @@
// Shared compare unit: checks one slot against the request key and cutoff.
// Depends on gcnt_pkg for the entry and compare result types.
module gcnt_cmp
   import gcnt_pkg::*;
(
   input  gcnt_entry_type     entry,
   input  logic [KEY_W-1:0]   key,
   input  logic [SEC_W-1:0]   cutoff_sec,
   output gcnt_cmp_type       result
);

   // A slot only matches or ages out while it holds a live key.
   assign result.key_hit = entry.vld && (entry.key == key);
   assign result.stale   = entry.vld && (entry.last_sec <= cutoff_sec);

endmodule

@@ rtl/gcnt_seq.sv @@
// Sequencer of the counter table: scans the slot RAM through the compare unit,
// updates slots and holds the response register.
// Depends on gcnt_pkg, gcnt_ram and gcnt_cmp.
module gcnt_seq
   import gcnt_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] start_count,
   input  logic               req_valid,
   output logic               req_stall,
   input  gcnt_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gcnt_rsp_type       rsp_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int EW = $bits(gcnt_entry_type);
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_WRITE = 5'b01000,
      S_DONE  = 5'b10000
   } gcnt_state_type;

   gcnt_state_type      state_ff, state_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]       cmp_addr_ff, cmp_addr_in;
   gcnt_req_type        req_ff, req_in;
   logic                hit_ff, hit_in;
   logic                free_found_ff, free_found_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic [COUNT_W-1:0]  hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]  res_count_ff, res_count_in;
   logic                res_full_ff, res_full_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gcnt_rsp_type        rsp_data_ff, rsp_data_in;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       rd_word;
   gcnt_entry_type      rd_entry;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   gcnt_entry_type      wr_entry;
   gcnt_cmp_type        cmp_res;
   logic [COUNT_W-1:0]  base_count;
   logic                is_mark;

   // Slot storage.
   gcnt_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = gcnt_entry_type'(rd_word);

   // Compare unit shared by lookup and sweep.
   gcnt_cmp u_cmp (
      .entry      (rd_entry),
      .key        (req_ff.key),
      .cutoff_sec (req_ff.cutoff_sec),
      .result     (cmp_res)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign is_mark    = (req_ff.mode == MODE_MARK);
   assign base_count = hit_ff ? hit_count_ff : start_count;

   // Next-state and datapath control.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_addr_in   = addr_ff;
      req_in        = req_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      slot_in       = slot_ff;
      hit_count_in  = hit_count_ff;
      res_count_in  = res_count_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_entry      = '0;

      case (state_ff)
         S_CLEAR: begin
            // Mark every slot empty, one per cycle.
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               addr_in       = '0;
               if (req_data.mode == MODE_MARK || req_data.mode == MODE_UNMARK ||
                   req_data.mode == MODE_SWEEP) begin
                  issue_in = 1'b1;
                  state_in = S_SCAN;
               end else begin
                  res_count_in = '0;
                  res_full_in  = 1'b0;
                  state_in     = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // Read stage: issue one slot read per cycle.
            rd_en      = issue_ff;
            cmp_vld_in = issue_ff;
            if (issue_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == LAST) begin
                  issue_in = 1'b0;
               end
            end
            // Compare stage: act on the slot read last cycle.
            if (cmp_vld_ff) begin
               if (req_ff.mode == MODE_SWEEP) begin
                  if (cmp_res.stale) begin
                     wr_en   = 1'b1;
                     wr_addr = cmp_addr_ff;
                  end
                  if (cmp_addr_ff == LAST) begin
                     res_count_in = '0;
                     res_full_in  = 1'b0;
                     state_in     = S_DONE;
                  end
               end else if (cmp_res.key_hit) begin
                  hit_in       = 1'b1;
                  slot_in      = cmp_addr_ff;
                  hit_count_in = rd_entry.count;
                  issue_in     = 1'b0;
                  cmp_vld_in   = 1'b0;
                  state_in     = S_WRITE;
               end else begin
                  if (!rd_entry.vld && !free_found_ff) begin
                     free_found_in = 1'b1;
                     slot_in       = cmp_addr_ff;
                  end
                  if (cmp_addr_ff == LAST) begin
                     state_in = S_WRITE;
                  end
               end
            end
         end
         S_WRITE: begin
            // Store the updated or new slot, or report a full table.
            if (hit_ff || free_found_ff) begin
               wr_en             = 1'b1;
               wr_addr           = slot_ff;
               wr_entry.vld      = 1'b1;
               wr_entry.key      = req_ff.key;
               wr_entry.count    = is_mark ? gcnt_sat_inc(base_count) : start_count;
               wr_entry.last_sec = req_ff.now_sec;
               res_count_in      = is_mark ? base_count : start_count;
               res_full_in       = 1'b0;
            end else begin
               res_count_in = start_count;
               res_full_in  = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the response register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.count      = res_count_ff;
               rsp_data_in.table_full = res_full_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         addr_ff       <= '0;
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmp_addr_ff  <= cmp_addr_in;
      req_ff       <= req_in;
      slot_ff      <= slot_in;
      hit_count_ff <= hit_count_in;
      res_count_ff <= res_count_in;
      res_full_ff  <= res_full_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // A slot write from the update state always has a target slot.
   a_write_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && !res_full_in) |-> (hit_ff || free_found_ff))
      else $error("slot update without a hit or free slot");

   // A full-table result means no match and no free slot was seen.
   a_full_means_none: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && res_full_in) |-> (!hit_ff && !free_found_ff && !wr_en))
      else $error("full table reported while a slot was available");

   // Sweeping and clearing only ever empty slots.
   a_sweep_clears: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == S_SCAN || state_ff == S_CLEAR)) |-> !wr_entry.vld)
      else $error("sweep or clear wrote a live slot");

   // The compare stage always follows a read issued the cycle before.
   a_cmp_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(rd_en))
      else $error("compare without a preceding slot read");

endmodule

@@ rtl/keyed_generation_counter_table_top.sv @@
// Top level of the keyed generation counter table.
// Holds the start count register; depends on gcnt_pkg and gcnt_seq.
//
//   Port group   Direction  Handshake         Payload
//   req_*        in         req_valid/stall   gcnt_req_type (mode, key, now, cutoff)
//   rsp_*        out        rsp_valid/stall   gcnt_rsp_type (count, table_full)
//   csr_*        in         csr_valid/ready   start count, 31 bits
//
// After reset the slot RAM is cleared; requests stall while it is.
// Mark and unmark scan one slot per cycle through a single RAM read port and
// stop at the first matching key.
// A sweep always reads all ENTRIES slots.
// A request can be taken while the previous response is still stalled.
module keyed_generation_counter_table_top
   import gcnt_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gcnt_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gcnt_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   logic [COUNT_W-1:0] start_count_ff, start_count_in;

   // Start count register; writes are always taken.
   assign csr_ready      = 1'b1;
   assign start_count_in = (csr_valid && csr_ready) ? csr_data : start_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_count_ff <= '0;
      end else begin
         start_count_ff <= start_count_in;
      end
   end

   // Table sequencer with slot storage.
   gcnt_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_count (start_count_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

@@ sim/keyed_generation_counter_table_top_tb.sv @@
// Self-checking testbench for keyed_generation_counter_table_top.
// Drives mark, unmark, sweep and unused-mode requests, checks every response against
// the directed plan or its own copy of the table, and depends only on gcnt_pkg and the top-level RTL.
`timescale 1ns / 1ps

module keyed_generation_counter_table_top_tb;
   import gcnt_pkg::*;

   localparam int TABLE_SLOTS = 256;
   localparam int KEY_POOL    = 12;
   localparam int CYCLE_LIMIT = 1200000;
   localparam int LONG_HOLD   = 2000;
   localparam int IDLE_PCT    = 8;

   // Mode code that the block must treat as a no-op.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // One row of the directed plan: either a start count write or a request.
   typedef struct {
      bit                 is_cfg;
      logic [COUNT_W-1:0] cfg_val;
      gcnt_req_type       req;
      bit                 typed;
      gcnt_rsp_type       rsp;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   gcnt_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   gcnt_rsp_type       rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   // Shadow copy of the table and of the start count register.
   bit                 slot_used [TABLE_SLOTS];
   logic [KEY_W-1:0]   slot_key  [TABLE_SLOTS];
   logic [COUNT_W-1:0] slot_count[TABLE_SLOTS];
   logic [SEC_W-1:0]   slot_seen [TABLE_SLOTS];
   logic [COUNT_W-1:0] start_count_shadow;

   gcnt_rsp_type       expected_counts_q[$];
   logic [KEY_W-1:0]   key_pool[KEY_POOL];
   logic [SEC_W-1:0]   cur_sec;
   plan_row_type       plan[24];

   int                 failures;
   int                 cycle_count;
   bit                 no_idle;
   int                 hold_asked;
   int                 hold_served;
   int                 hold_left;

   keyed_generation_counter_table_top #(
      .ENTRIES(TABLE_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL keyed_generation_counter_table_top");
         $finish;
      end
   end

   // Works out the response of one request and updates the shadow table.
   function automatic gcnt_rsp_type predict_generation(input gcnt_req_type r);
      gcnt_rsp_type res;
      int           slot;
      int           i;
      res  = '0;
      slot = -1;
      if (r.mode == MODE_MARK || r.mode == MODE_UNMARK) begin
         for (i = 0; i < TABLE_SLOTS; i++)
            if (slot < 0 && slot_used[i] && slot_key[i] == r.key) slot = i;
         // An absent key takes the lowest free slot.
         if (slot < 0) begin
            for (i = 0; i < TABLE_SLOTS; i++)
               if (slot < 0 && !slot_used[i]) slot = i;
            if (slot >= 0) begin
               slot_used[slot]  = 1'b1;
               slot_key[slot]   = r.key;
               slot_count[slot] = start_count_shadow;
            end
         end
         if (slot < 0) begin
            res.count      = start_count_shadow;
            res.table_full = 1'b1;
         end else begin
            slot_seen[slot] = r.now_sec;
            if (r.mode == MODE_MARK) begin
               res.count = slot_count[slot];
               if (slot_count[slot] != COUNT_MAX) slot_count[slot] = slot_count[slot] + 1'b1;
            end else begin
               slot_count[slot] = start_count_shadow;
               res.count        = start_count_shadow;
            end
         end
      end else if (r.mode == MODE_SWEEP) begin
         for (i = 0; i < TABLE_SLOTS; i++)
            if (slot_used[i] && slot_seen[i] <= r.cutoff_sec) slot_used[i] = 1'b0;
      end
      return res;
   endfunction

   // Random request; fresh_pct sets how often the key is new to the table.
   function automatic gcnt_req_type random_request(input int fresh_pct);
      gcnt_req_type r;
      int           roll;
      cur_sec      = cur_sec + $urandom_range(0, 3);
      r.key        = ($urandom_range(99) < fresh_pct) ? {$urandom, $urandom}
                                                      : key_pool[$urandom_range(KEY_POOL - 1)];
      r.now_sec    = ($urandom_range(99) < 10) ? $urandom : cur_sec;
      r.cutoff_sec = $urandom;
      roll         = $urandom_range(99);
      if (roll < 55) r.mode = MODE_MARK;
      else if (roll < 82) r.mode = MODE_UNMARK;
      else if (roll < 97) r.mode = MODE_SWEEP;
      else r.mode = MODE_UNUSED;
      // Sweeps mostly age out entries a little older than now.
      if (r.mode == MODE_SWEEP) begin
         roll = $urandom_range(99);
         if (roll < 70) r.cutoff_sec = cur_sec - $urandom_range(0, 40);
         else if (roll < 80) r.cutoff_sec = '0;
         else if (roll < 85) r.cutoff_sec = '1;
      end
      return r;
   endfunction

   // Offers one request and records its expected response when accepted.
   task automatic offer_request(input gcnt_req_type r, input bit typed,
                                input gcnt_rsp_type typed_rsp);
      gcnt_rsp_type predicted;
      int           gap;
      gap = 0;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = predict_generation(r);
      expected_counts_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Lowers the request valid and waits for every outstanding response.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts_q.size() != 0) @(posedge clock);
   endtask

   // Writes the start count register while the block is idle.
   task automatic program_start_count(input logic [COUNT_W-1:0] val);
      wait_for_responses();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      start_count_shadow = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic plan_row_type req_row(input logic [MODE_W-1:0] mode,
                                            input logic [KEY_W-1:0] key,
                                            input logic [SEC_W-1:0] now_sec,
                                            input logic [SEC_W-1:0] cutoff_sec,
                                            input bit typed,
                                            input logic [COUNT_W-1:0] count,
                                            input logic full);
      plan_row_type row;
      row.is_cfg         = 1'b0;
      row.cfg_val        = '0;
      row.req.mode       = mode;
      row.req.key        = key;
      row.req.now_sec    = now_sec;
      row.req.cutoff_sec = cutoff_sec;
      row.typed          = typed;
      row.rsp.count      = count;
      row.rsp.table_full = full;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(input logic [COUNT_W-1:0] val);
      plan_row_type row;
      row         = req_row(MODE_MARK, '0, '0, '0, 1'b0, '0, 1'b0);
      row.is_cfg  = 1'b1;
      row.cfg_val = val;
      return row;
   endfunction

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin
      gcnt_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts_q.size() == 0) begin
            $error("response with no request outstanding: count=%0d table_full=%0b",
                   rsp_data.count, rsp_data.table_full);
            failures++;
         end else begin
            want = expected_counts_q.pop_front();
            if (rsp_data.count !== want.count) begin
               $error("count mismatch: expected %0d, actual %0d", want.count, rsp_data.count);
               failures++;
            end
            if (rsp_data.table_full !== want.table_full) begin
               $error("table_full mismatch: expected %0b, actual %0b",
                      want.table_full, rsp_data.table_full);
               failures++;
            end
         end
      end
   end

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_stall   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Main sequence.
   initial begin
      gcnt_req_type r;
      int           n;
      req_valid          = 1'b0;
      req_data           = '0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      reset              = 1'b1;
      failures           = 0;
      no_idle            = 1'b0;
      hold_asked         = 0;
      start_count_shadow = '0;
      cur_sec            = $urandom_range(1000, 100000);
      for (n = 0; n < TABLE_SLOTS; n++) slot_used[n] = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {1'b1, {(KEY_W-1){1'b0}}};
      key_pool[3] = 64'd1;
      for (n = 4; n < KEY_POOL; n++) key_pool[n] = {$urandom, $urandom};

      // Directed plan, starting from the reset start count of zero.
      plan[0]  = req_row(MODE_MARK,   '0, '0, '1, 1'b1, 31'd0, 1'b0);
      plan[1]  = req_row(MODE_MARK,   '0, 32'd1, '0, 1'b1, 31'd1, 1'b0);
      plan[2]  = req_row(MODE_MARK,   '1, '1, '0, 1'b1, 31'd0, 1'b0);
      plan[3]  = req_row(MODE_UNMARK, '0, 32'd2, '1, 1'b1, 31'd0, 1'b0);
      plan[4]  = req_row(MODE_MARK,   '0, 32'd3, '0, 1'b1, 31'd0, 1'b0);
      plan[5]  = req_row(MODE_UNUSED, 64'h1234, '1, '1, 1'b1, 31'd0, 1'b0);
      plan[6]  = req_row(MODE_MARK,   '0, 32'd4, '1, 1'b1, 31'd1, 1'b0);
      plan[7]  = req_row(MODE_SWEEP,  '1, '1, 32'd3, 1'b1, 31'd0, 1'b0);
      plan[8]  = req_row(MODE_SWEEP,  '0, '0, 32'd4, 1'b1, 31'd0, 1'b0);
      plan[9]  = req_row(MODE_MARK,   '0, 32'd5, '0, 1'b1, 31'd0, 1'b0);
      plan[10] = cfg_row(COUNT_MAX - 1'b1);
      // Counter saturation on repeated marks of one key.
      plan[11] = req_row(MODE_MARK,   key_pool[2], 32'd10, '0, 1'b1, COUNT_MAX - 1'b1, 1'b0);
      plan[12] = req_row(MODE_MARK,   key_pool[2], 32'd10, '0, 1'b1, COUNT_MAX, 1'b0);
      plan[13] = req_row(MODE_MARK,   key_pool[2], 32'd10, '0, 1'b1, COUNT_MAX, 1'b0);
      plan[14] = req_row(MODE_UNMARK, key_pool[2], 32'd10, '0, 1'b1, COUNT_MAX - 1'b1, 1'b0);
      plan[15] = req_row(MODE_MARK,   '0, 32'd11, '0, 1'b0, '0, 1'b0);
      plan[16] = req_row(MODE_UNMARK, '1, 32'd12, '0, 1'b1, COUNT_MAX - 1'b1, 1'b0);
      plan[17] = req_row(MODE_SWEEP,  '0, '0, '1, 1'b1, 31'd0, 1'b0);
      plan[18] = req_row(MODE_MARK,   '0, 32'd13, '0, 1'b1, COUNT_MAX - 1'b1, 1'b0);
      plan[19] = cfg_row(31'h5555_5555);
      plan[20] = req_row(MODE_MARK,   64'h5555_5555_5555_5555, 32'hAAAA_AAAA, '0,
                         1'b1, 31'h5555_5555, 1'b0);
      plan[21] = cfg_row(31'h2AAA_AAAA);
      plan[22] = req_row(MODE_UNMARK, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
                         32'hAAAA_AAAA, 1'b1, 31'h2AAA_AAAA, 1'b0);
      plan[23] = req_row(MODE_SWEEP,  64'h5555_5555_5555_5555, '1, 32'h7FFF_FFFF,
                         1'b0, '0, 1'b0);

      // Synchronous reset; the block clears its slot memory afterwards.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) program_start_count(plan[i].cfg_val);
         else offer_request(plan[i].req, plan[i].typed, plan[i].rsp);
      end

      // Mixed traffic on a small key pool, with a long response hold-off,
      // a full drain and a stretch without any idling.
      program_start_count(COUNT_W'($urandom));
      for (n = 0; n < 250; n++) begin
         if (n == 50) hold_asked++;
         if (n == 120) wait_for_responses();
         no_idle = (n >= 150);
         offer_request(random_request(5), 1'b0, '0);
      end
      no_idle = 1'b0;

      // Fill the table with fresh keys until inserts report a full table.
      program_start_count(COUNT_MAX);
      for (n = 0; n < 280; n++) begin
         cur_sec      = cur_sec + $urandom_range(0, 2);
         r.mode       = ($urandom_range(99) < 80) ? MODE_MARK : MODE_UNMARK;
         r.key        = {$urandom, $urandom};
         r.now_sec    = cur_sec;
         r.cutoff_sec = $urandom;
         offer_request(r, 1'b0, '0);
      end
      for (n = 0; n < 60; n++) offer_request(random_request(30), 1'b0, '0);

      // Empty the table, then mixed traffic with the lowest start count.
      program_start_count('0);
      r.mode       = MODE_SWEEP;
      r.key        = {$urandom, $urandom};
      r.now_sec    = $urandom;
      r.cutoff_sec = '1;
      offer_request(r, 1'b0, '0);
      for (n = 0; n < 340; n++) offer_request(random_request(10), 1'b0, '0);

      wait_for_responses();
      repeat (16) @(posedge clock);
      if (failures == 0) begin
         $display("PASS keyed_generation_counter_table_top");
      end else begin
         $display("FAIL keyed_generation_counter_table_top");
      end
      $finish;
   end

endmodule
